// File: rtl/dig_ed_pkg.sv
// Shared types, switch codes and elaboration-time table helpers for the digit editor.
`default_nettype none

package dig_ed_pkg;

  localparam logic [4:0] SW_COMMIT = 5'd1;
  localparam logic [4:0] SW_RIGHT  = 5'd2;
  localparam logic [4:0] SW_SUB    = 5'd4;
  localparam logic [4:0] SW_LEFT   = 5'd8;
  localparam logic [4:0] SW_ADD    = 5'd16;

  typedef enum logic [1:0] {
    STAT_NONE   = 2'd0,
    STAT_DONE   = 2'd1,
    STAT_REJECT = 2'd2
  } commit_status_e;

  typedef enum logic [1:0] {
    ADD_PLAIN,
    ADD_WRAP,
    SUB_PLAIN,
    SUB_WRAP
  } addend_kind_e;

  typedef struct packed {
    logic [15:0]    entry;
    logic [1:0]     cursor;
    logic [15:0]    bcd;
    logic           too_high;
    commit_status_e status;
  } dig_ed_result_t;

  // Decimal digits needed to hold 16^digits - 1.
  function automatic int dec_digits(input int digits);
    longint unsigned m;
    int              count;
    int              i;
    m     = (64'd1 << (4 * digits)) - 64'd1;
    count = 0;
    for (i = 0; i < 20; i++) begin
      if (m != 64'd0) begin
        count = count + 1;
        m     = m / 10;
      end
    end
    return count;
  endfunction

  // Packed BCD of a constant, n digits.
  function automatic logic [63:0] bcd_of(input longint unsigned v, input int n);
    logic [63:0]     res;
    longint unsigned rem;
    int              i;
    res = '0;
    rem = v;
    for (i = 0; i < 16; i++) begin
      if (i < n) begin
        res[4*i +: 4] = 4'(rem % 10);
        rem           = rem / 10;
      end
    end
    return res;
  endfunction

  // Decimal addend, modulo 10^n, that tracks one hex edit at a cursor.
  function automatic logic [63:0] addend(input int digits, input int cur,
                                         input addend_kind_e kind);
    longint unsigned w;
    longint unsigned m;
    longint unsigned p;
    longint unsigned v;
    int              n;
    int              i;
    w = 64'd1 << (4 * (digits - 1 - cur));
    m = 64'd1 << (4 * digits);
    n = dec_digits(digits);
    p = 64'd1;
    for (i = 0; i < 16; i++) begin
      if (i < n) begin
        p = p * 10;
      end
    end
    case (kind)
      ADD_PLAIN: v = w;
      ADD_WRAP:  v = p - (m - w);
      SUB_PLAIN: v = p - w;
      SUB_WRAP:  v = m - w;
      default:   v = 64'd0;
    endcase
    return bcd_of(v, n);
  endfunction

endpackage

`default_nettype wire

// File: rtl/digit_editor_with_bcd_commit.sv
// Top level of the digit editor: input handshake, core and result register.
`default_nettype none

// Takes one switch beat per cycle and returns one result beat for each, in the next cycle
// from a result register; a new beat is taken while a finished result waits, and input
// stalls only when that register is full and the output stalls. The rate is set by the
// combinational update path: a hex add or subtract on the entry and a ripple BCD add on a
// decimal shadow of the entry, so a commit only checks the shadow's upper digits and
// copies its lower ones. No clearing pass is needed after reset.
module digit_editor_with_bcd_commit
  import dig_ed_pkg::*;
#(
  parameter int DIGITS = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [4:0]  switch_code_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic      [15:0] entry_shown_o,
  output logic      [1:0]  cursor_shown_o,
  output logic      [15:0] bcd_shown_o,
  output logic             too_high_flag_o,
  output logic      [1:0]  commit_status_o
);

  logic           step;
  logic           out_valid_q, out_valid_d;
  dig_ed_result_t res_next;
  dig_ed_result_t res_q;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign step       = in_valid_i & ~in_stall_o;

  dig_ed_core #(
    .DIGITS (DIGITS)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .switch_code_i (switch_code_i),
    .result_o      (res_next)
  );

  always_comb begin
    if (step) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res_next;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign entry_shown_o   = res_q.entry;
  assign cursor_shown_o  = res_q.cursor;
  assign bcd_shown_o     = res_q.bcd;
  assign too_high_flag_o = res_q.too_high;
  assign commit_status_o = res_q.status;

  a_step_gives_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_valid_o)
    else $error("accepted beat did not produce a result beat");

  a_stall_needs_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with an empty result register");

  a_reject_sets_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && res_q.status == STAT_REJECT) |-> too_high_flag_o)
    else $error("rejected commit without the too-high flag");

  a_done_clears_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && res_q.status == STAT_DONE) |-> !too_high_flag_o)
    else $error("converted commit left the too-high flag set");

endmodule

`default_nettype wire

// File: rtl/dig_ed_bcd_add.sv
// Ripple BCD adder, result modulo 10^N.
`default_nettype none

module dig_ed_bcd_add #(
  parameter int N = 5
) (
  input  wire logic [4*N-1:0] a_i,
  input  wire logic [4*N-1:0] b_i,
  output logic      [4*N-1:0] sum_o
);

  logic [N-1:0] carry;

  assign carry[0] = 1'b0;

  for (genvar i = 0; i < N; i++) begin : g_digit
    logic [4:0] raw;
    logic       over;
    assign raw  = {1'b0, a_i[4*i +: 4]} + {1'b0, b_i[4*i +: 4]} + 5'(carry[i]);
    assign over = raw > 5'd9;
    assign sum_o[4*i +: 4] = over ? 4'(raw + 5'd6) : raw[3:0];
    if (i < N - 1) begin : g_carry
      assign carry[i+1] = over;
    end
  end

endmodule

`default_nettype wire

// File: rtl/dig_ed_core.sv
// Entry, cursor, decimal shadow and BCD state with the per-beat update logic.
`default_nettype none

module dig_ed_core
  import dig_ed_pkg::*;
#(
  parameter int DIGITS = 4
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       step_i,
  input  wire logic [4:0] switch_code_i,
  output dig_ed_result_t  result_o
);

  localparam int EW   = 4 * DIGITS;
  localparam int CW   = $clog2(DIGITS);
  localparam int NDEC = dec_digits(DIGITS);
  localparam int DW   = 4 * NDEC;

  logic [EW-1:0]     entry_q, entry_d;
  logic [CW-1:0]     cursor_q, cursor_d;
  logic [EW-1:0]     bcd_q, bcd_d;
  logic              err_q, err_d;
  logic [DW-1:0]     dec_q, dec_d;
  commit_status_e    status;

  logic [CW-1:0]     rev;
  logic [EW-1:0]     weight;
  logic [EW:0]       add_sum;
  logic [EW:0]       sub_diff;
  logic [DW-1:0]     dec_addend;
  logic [DW-1:0]     dec_sum;
  logic              in_range;

  logic [DW-1:0]     tab_ap [DIGITS];
  logic [DW-1:0]     tab_aw [DIGITS];
  logic [DW-1:0]     tab_sp [DIGITS];
  logic [DW-1:0]     tab_sw [DIGITS];

  for (genvar c = 0; c < DIGITS; c++) begin : g_tab
    localparam logic [63:0] AP = addend(DIGITS, c, ADD_PLAIN);
    localparam logic [63:0] AW = addend(DIGITS, c, ADD_WRAP);
    localparam logic [63:0] SP = addend(DIGITS, c, SUB_PLAIN);
    localparam logic [63:0] SWR = addend(DIGITS, c, SUB_WRAP);
    assign tab_ap[c] = AP[DW-1:0];
    assign tab_aw[c] = AW[DW-1:0];
    assign tab_sp[c] = SP[DW-1:0];
    assign tab_sw[c] = SWR[DW-1:0];
  end

  assign rev      = CW'(DIGITS - 1) - cursor_q;
  assign weight   = EW'(1) << {rev, 2'b00};
  assign add_sum  = {1'b0, entry_q} + {1'b0, weight};
  assign sub_diff = {1'b0, entry_q} - {1'b0, weight};
  assign in_range = dec_q[DW-1:EW] == '0;

  always_comb begin
    if (switch_code_i == SW_SUB) begin
      dec_addend = sub_diff[EW] ? tab_sw[cursor_q] : tab_sp[cursor_q];
    end else begin
      dec_addend = add_sum[EW] ? tab_aw[cursor_q] : tab_ap[cursor_q];
    end
  end

  dig_ed_bcd_add #(
    .N (NDEC)
  ) u_bcd_add (
    .a_i   (dec_q),
    .b_i   (dec_addend),
    .sum_o (dec_sum)
  );

  always_comb begin
    entry_d  = entry_q;
    cursor_d = cursor_q;
    bcd_d    = bcd_q;
    err_d    = err_q;
    dec_d    = dec_q;
    status   = STAT_NONE;
    case (switch_code_i)
      SW_SUB: begin
        entry_d = sub_diff[EW-1:0];
        dec_d   = dec_sum;
        err_d   = 1'b0;
      end
      SW_ADD: begin
        entry_d = add_sum[EW-1:0];
        dec_d   = dec_sum;
        err_d   = 1'b0;
      end
      SW_RIGHT: begin
        if (cursor_q != CW'(DIGITS - 1)) begin
          cursor_d = cursor_q + CW'(1);
        end
        err_d = 1'b0;
      end
      SW_LEFT: begin
        if (cursor_q != '0) begin
          cursor_d = cursor_q - CW'(1);
        end
        err_d = 1'b0;
      end
      SW_COMMIT: begin
        if (in_range) begin
          bcd_d  = dec_q[EW-1:0];
          err_d  = 1'b0;
          status = STAT_DONE;
        end else begin
          err_d  = 1'b1;
          status = STAT_REJECT;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q  <= '0;
      cursor_q <= CW'(DIGITS - 1);
      bcd_q    <= '0;
      err_q    <= 1'b0;
      dec_q    <= '0;
    end else if (step_i) begin
      entry_q  <= entry_d;
      cursor_q <= cursor_d;
      bcd_q    <= bcd_d;
      err_q    <= err_d;
      dec_q    <= dec_d;
    end
  end

  assign result_o.entry    = 16'(entry_d);
  assign result_o.cursor   = 2'(cursor_d);
  assign result_o.bcd      = 16'(bcd_d);
  assign result_o.too_high = err_d;
  assign result_o.status   = status;

endmodule

`default_nettype wire

// File: sim/digit_editor_with_bcd_commit_tb.sv
// Testbench for the digit editor: directed and random switch beats checked against a predictor.
`timescale 1ns / 1ps

module digit_editor_with_bcd_commit_tb;
  import dig_ed_pkg::*;

  localparam int          CLK_HIGH_NS  = 6;
  localparam int          CLK_LOW_NS   = 6;
  localparam int          RESET_CYCLES = 10;
  localparam int          HOLD_CYCLES  = 80;
  localparam int          MAX_REPORTS  = 10;
  localparam int          DRAIN_LIMIT  = 2000;
  localparam int          RANDOM_BEATS = 360;
  localparam logic [15:0] ENTRY_LIMIT  = 16'h270F;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [4:0]  switch_code_i;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [15:0] entry_shown_o;
  logic [1:0]  cursor_shown_o;
  logic [15:0] bcd_shown_o;
  logic        too_high_flag_o;
  logic [1:0]  commit_status_o;

  // predicted state of the editor
  logic [15:0] entry_q;
  logic [1:0]  cursor_q;
  logic [15:0] bcd_q;
  logic        too_high_q;

  dig_ed_result_t pending_results[$];

  int send_idle_pct;
  int recv_idle_pct;
  logic hold_request = 1'b0;
  int   hold_left    = 0;

  int beats_sent;
  int results_checked;
  int error_count;
  int commits_converted;
  int commits_rejected;
  int codes_ignored;

  digit_editor_with_bcd_commit i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .switch_code_i   (switch_code_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .entry_shown_o   (entry_shown_o),
    .cursor_shown_o  (cursor_shown_o),
    .bcd_shown_o     (bcd_shown_o),
    .too_high_flag_o (too_high_flag_o),
    .commit_status_o (commit_status_o)
  );

  always begin
    #CLK_LOW_NS clk_i = 1'b1;
    #CLK_HIGH_NS clk_i = 1'b0;
  end

  function automatic logic [15:0] packed_decimal(input logic [15:0] value);
    logic [15:0] res;
    int unsigned rem;
    int unsigned div;
    int          i;
    res = '0;
    rem = 32'(value);
    div = 1000;
    for (i = 0; i < 4; i++) begin
      res = {res[11:0], 4'(rem / div)};
      rem = rem % div;
      div = div / 10;
    end
    return res;
  endfunction

  // Offer one beat, hold it until taken, then update the prediction.
  task automatic send_switch(input logic [4:0] code);
    dig_ed_result_t want;
    commit_status_e status;
    in_valid_i    <= 1'b1;
    switch_code_i <= code;
    do @(posedge clk_i); while (in_stall_o);
    status = STAT_NONE;
    case (code)
      SW_SUB: begin
        entry_q    = entry_q - (16'h1000 >> {cursor_q, 2'b00});
        too_high_q = 1'b0;
      end
      SW_ADD: begin
        entry_q    = entry_q + (16'h1000 >> {cursor_q, 2'b00});
        too_high_q = 1'b0;
      end
      SW_RIGHT: begin
        if (cursor_q != 2'd3) cursor_q = cursor_q + 2'd1;
        too_high_q = 1'b0;
      end
      SW_LEFT: begin
        if (cursor_q != 2'd0) cursor_q = cursor_q - 2'd1;
        too_high_q = 1'b0;
      end
      SW_COMMIT: begin
        if (entry_q > ENTRY_LIMIT) begin
          too_high_q = 1'b1;
          status     = STAT_REJECT;
          commits_rejected++;
        end else begin
          bcd_q      = packed_decimal(entry_q);
          too_high_q = 1'b0;
          status     = STAT_DONE;
          commits_converted++;
        end
      end
      default: codes_ignored++;
    endcase
    want.entry    = entry_q;
    want.cursor   = cursor_q;
    want.bcd      = bcd_q;
    want.too_high = too_high_q;
    want.status   = status;
    pending_results.push_back(want);
    beats_sent++;
    @(negedge clk_i);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i    <= 1'b0;
      switch_code_i <= 5'($urandom_range(31));
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
  endtask

  // Output side: random stalls, plus a long hold when asked.
  always @(negedge clk_i) begin
    if (hold_request) begin
      hold_request <= 1'b0;
      hold_left    <= HOLD_CYCLES;
      out_stall_i  <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin : check_beat
    dig_ed_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS) begin
          $display("%0t: result beat with none expected: entry %h cursor %0d bcd %h",
                   $realtime, entry_shown_o, cursor_shown_o, bcd_shown_o);
          $display("%0t:           flag %b st %0d",
                   $realtime, too_high_flag_o, commit_status_o);
        end
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (entry_shown_o !== want.entry || cursor_shown_o !== want.cursor ||
            bcd_shown_o !== want.bcd || too_high_flag_o !== want.too_high ||
            commit_status_o !== want.status) begin
          error_count++;
          if (error_count <= MAX_REPORTS) begin
            $display("%0t: mismatch, expected entry %h cursor %0d bcd %h flag %b st %0d",
                     $realtime, want.entry, want.cursor, want.bcd, want.too_high,
                     want.status);
            $display("%0t:           got      entry %h cursor %0d bcd %h flag %b st %0d",
                     $realtime, entry_shown_o, cursor_shown_o, bcd_shown_o,
                     too_high_flag_o, commit_status_o);
          end
        end
      end
    end
  end

  task automatic test_commit_basics;
    send_switch(SW_COMMIT);
    send_switch(SW_RIGHT);
    send_switch(SW_ADD);
    send_switch(SW_SUB);
  endtask

  task automatic test_wrap_and_reject;
    send_switch(SW_SUB);
    send_switch(SW_COMMIT);
    send_switch(SW_RIGHT);
    send_switch(SW_COMMIT);
    send_switch(SW_ADD);
  endtask

  task automatic test_cursor_ends;
    send_switch(SW_LEFT);
    send_switch(SW_LEFT);
    send_switch(SW_LEFT);
    send_switch(SW_LEFT);
    send_switch(SW_ADD);
    send_switch(SW_COMMIT);
    send_switch(SW_SUB);
    send_switch(SW_SUB);
    send_switch(SW_COMMIT);
  endtask

  task automatic test_ignored_codes;
    send_switch(5'd0);
    send_switch(5'd31);
    send_switch(5'd3);
    send_switch(5'd24);
    send_switch(SW_ADD);
    send_switch(SW_COMMIT);
  endtask

  task automatic run_random(input int count);
    int         k;
    int         pick;
    logic [4:0] code;
    for (k = 0; k < count; k++) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        code = 5'($urandom_range(31));
      end else if (pick < 22) begin
        code = SW_COMMIT;
      end else if (entry_q > ENTRY_LIMIT && $urandom_range(1) == 1) begin
        code = (cursor_q != 2'd0) ? SW_LEFT : SW_SUB;
      end else begin
        case ($urandom_range(3))
          0:       code = SW_ADD;
          1:       code = SW_SUB;
          2:       code = SW_LEFT;
          default: code = SW_RIGHT;
        endcase
      end
      send_switch(code);
    end
  endtask

  task automatic test_receiver_hold;
    hold_request <= 1'b1;
    run_random(16);
  endtask

  initial begin
    int drain_cycles;
    in_valid_i        = 1'b0;
    switch_code_i     = '0;
    rst_ni            = 1'b0;
    send_idle_pct     = 0;
    recv_idle_pct     = 0;
    entry_q           = '0;
    cursor_q          = 2'd3;
    bcd_q             = '0;
    too_high_q        = 1'b0;
    beats_sent        = 0;
    results_checked   = 0;
    error_count       = 0;
    commits_converted = 0;
    commits_rejected  = 0;
    codes_ignored     = 0;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_idle_pct = 37;
    recv_idle_pct = 83;
    test_commit_basics();
    test_wrap_and_reject();
    test_cursor_ends();
    test_ignored_codes();
    run_random(RANDOM_BEATS);

    send_idle_pct = 83;
    recv_idle_pct = 37;
    run_random(RANDOM_BEATS);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_receiver_hold();
    run_random(RANDOM_BEATS);

    in_valid_i <= 1'b0;
    drain_cycles = 0;
    while (pending_results.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
      @(posedge clk_i);
      drain_cycles++;
    end
    repeat (4) @(posedge clk_i);
    error_count += pending_results.size();

    $display("Sent %0d switch beats, checked %0d result beats, %0d failures",
             beats_sent, results_checked, error_count);
    $display("Commits converted %0d, rejected %0d; ignored codes %0d",
             commits_converted, commits_rejected, codes_ignored);
    if (error_count == 0) begin
      $display("PASS digit_editor_with_bcd_commit");
    end else begin
      $display("FAIL digit_editor_with_bcd_commit");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAIL digit_editor_with_bcd_commit");
    $finish;
  end

endmodule

// File: files.f
rtl/dig_ed_pkg.sv
rtl/dig_ed_bcd_add.sv
rtl/dig_ed_core.sv
rtl/digit_editor_with_bcd_commit.sv
sim/digit_editor_with_bcd_commit_tb.sv
